// File: rtl/core/assert_macros.svh
// Assertion macros used by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/core/cfale_pkg.sv
// Package: constants and helpers of the CAN frame ASCII line encoder.
package cfale_pkg;

  localparam int KindW    = 2;
  localparam int IdW      = 29;
  localparam int StdIdW   = 11;
  localparam int LenW     = 4;
  localparam int PayloadW = 64;
  localparam int CharW    = 8;
  localparam int IdSrW    = 32;  // eight nibbles
  localparam int ByteW    = 8;

  localparam logic [KindW-1:0] KindBad   = 2'd0;
  localparam logic [KindW-1:0] KindFrame = 2'd1;

  localparam logic [CharW-1:0] CharBel     = 8'd7;
  localparam logic [CharW-1:0] CharCr      = 8'd13;
  localparam logic [CharW-1:0] CharStdData = 8'h74;  // t
  localparam logic [CharW-1:0] CharExtData = 8'h54;  // T
  localparam logic [CharW-1:0] CharStdRtr  = 8'h72;  // r
  localparam logic [CharW-1:0] CharExtRtr  = 8'h52;  // R
  localparam logic [CharW-1:0] CharZero    = 8'h30;  // 0
  localparam logic [CharW-1:0] CharUpperA  = 8'h41;  // A

  // Uppercase hex digit for one nibble.
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] v);
    logic [CharW-1:0] w;
    w = {4'b0000, v};
    if (v < 4'd10) begin
      return w + CharZero;
    end
    return w - 8'd10 + CharUpperA;
  endfunction

endpackage

// File: rtl/core/cfale_if.sv
// Valid/ready channel interfaces for packet descriptors and output characters.
interface cfale_in_if import cfale_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    packet_kind;
  logic                remote_request;
  logic                extended_id;
  logic [IdW-1:0]      identifier;
  logic [LenW-1:0]     data_length;
  logic [PayloadW-1:0] payload;

  modport source (output valid, packet_kind, remote_request, extended_id,
                  identifier, data_length, payload, input ready);
  modport sink   (input valid, packet_kind, remote_request, extended_id,
                  identifier, data_length, payload, output ready);
endinterface

interface cfale_out_if import cfale_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] text_char;
  logic             last_char;

  modport source (output valid, text_char, last_char, input ready);
  modport sink   (input valid, text_char, last_char, output ready);
endinterface

// File: rtl/core/can_frame_ascii_line_encoder.sv
// Top level: CAN frame descriptor to serial-line ASCII text encoder.
//
// Each input item is one packet descriptor; the block emits its text one
// character per output item, with last_char set on the final one. A bad
// packet gives BEL, a command (kind 2 or 3) gives CR, and a CAN frame gives
// a type letter (t/T/r/R), 3 or 8 uppercase hex digits of the identifier,
// the length code digit, two digits per data byte (data frames only, at
// most 8 bytes) and CR. Throughput is one character per clock, while the
// sink takes them, from a nibble-serial sequencer: the identifier shifts
// out of a 32-bit register four bits a cycle, the payload out of a 64-bit
// register one byte per pair of data characters. An item has 1, or 6 to
// 27, characters; the next item is accepted in the cycle its predecessor's
// final character is loaded, so lines follow back to back. The output
// register lets the sequencer run one character ahead of a stalled sink.
module can_frame_ascii_line_encoder import cfale_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfale_in_if.sink     in_i,
  cfale_out_if.source  out_o
);
`include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_BEL,
    S_LETTER,
    S_ID,
    S_LEN,
    S_DATA,
    S_CR
  } state_e;

  state_e              state_q;
  logic                rtr_q;
  logic                ext_q;
  logic [IdSrW-1:0]    id_sr_q;     // next id nibble in the top four bits
  logic [LenW-1:0]     len_q;
  logic [PayloadW-1:0] pl_sr_q;     // next byte in the low eight bits
  logic [2:0]          cnt_q;       // digits or bytes left, minus one
  logic                phase_q;     // 0: high nibble, 1: low nibble
  logic                ovalid_q;
  logic [CharW-1:0]    char_q;
  logic                last_q;

  logic                adv;
  logic                emit;
  logic                final_st;
  logic                in_acc;
  logic [CharW-1:0]    char_d;
  logic                last_d;
  logic [3:0]          data_nib;
  logic                data_hi;

  // Output register free, or its item leaves this cycle.
  assign adv      = !ovalid_q || out_o.ready;
  assign emit     = (state_q != S_IDLE) && adv;
  assign final_st = (state_q == S_CR) || (state_q == S_BEL);
  assign in_i.ready = (state_q == S_IDLE) || (final_st && adv);
  assign in_acc   = in_i.valid && in_i.ready;

  assign data_nib = phase_q ? pl_sr_q[3:0] : pl_sr_q[7:4];
  // High nibble of a data byte goes out this cycle.
  assign data_hi  = emit && (state_q == S_DATA) && !phase_q;

  always_comb begin
    char_d = CharCr;
    last_d = 1'b0;
    case (state_q)
      S_BEL: begin
        char_d = CharBel;
        last_d = 1'b1;
      end
      S_LETTER: begin
        if (rtr_q) begin
          char_d = ext_q ? CharExtRtr : CharStdRtr;
        end else begin
          char_d = ext_q ? CharExtData : CharStdData;
        end
      end
      S_ID:   char_d = hex_char(id_sr_q[IdSrW-1 -: 4]);
      S_LEN:  char_d = hex_char(len_q);
      S_DATA: char_d = hex_char(data_nib);
      S_CR: begin
        char_d = CharCr;
        last_d = 1'b1;
      end
      default: begin
        char_d = CharCr;
        last_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      phase_q  <= 1'b0;
    end else begin
      if (emit) begin
        ovalid_q <= 1'b1;
        char_q   <= char_d;
        last_q   <= last_d;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end

      if (in_acc) begin
        rtr_q   <= in_i.remote_request;
        ext_q   <= in_i.extended_id;
        len_q   <= in_i.data_length;
        pl_sr_q <= in_i.payload;
        phase_q <= 1'b0;
        if (in_i.extended_id) begin
          id_sr_q <= {{(IdSrW-IdW){1'b0}}, in_i.identifier};
          cnt_q   <= 3'd7;
        end else begin
          // 11 bits padded to three nibbles, left aligned
          id_sr_q <= {1'b0, in_i.identifier[StdIdW-1:0], {(IdSrW-StdIdW-1){1'b0}}};
          cnt_q   <= 3'd2;
        end
        case (in_i.packet_kind)
          KindBad:   state_q <= S_BEL;
          KindFrame: state_q <= S_LETTER;
          default:   state_q <= S_CR;
        endcase
      end else if (emit) begin
        case (state_q)
          S_LETTER: state_q <= S_ID;
          S_ID: begin
            id_sr_q <= {id_sr_q[IdSrW-5:0], 4'b0000};
            if (cnt_q == 3'd0) begin
              state_q <= S_LEN;
            end else begin
              cnt_q <= cnt_q - 3'd1;
            end
          end
          S_LEN: begin
            if (!rtr_q && (len_q != '0)) begin
              state_q <= S_DATA;
              phase_q <= 1'b0;
              cnt_q   <= len_q[3] ? 3'd7 : (len_q[2:0] - 3'd1);
            end else begin
              state_q <= S_CR;
            end
          end
          S_DATA: begin
            phase_q <= !phase_q;
            if (phase_q) begin
              pl_sr_q <= {{ByteW{1'b0}}, pl_sr_q[PayloadW-1:ByteW]};
              if (cnt_q == 3'd0) begin
                state_q <= S_CR;
              end else begin
                cnt_q <= cnt_q - 3'd1;
              end
            end
          end
          default: state_q <= S_IDLE;  // final character sent, no new item
        endcase
      end
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.text_char = char_q;
  assign out_o.last_char = last_q;

  // Final character of a line always carries the last flag.
  `ASSERT_PROP(a_last_on_final, clk_i, rst_ni, (emit && final_st) |=> out_o.last_char)
  // A new item is never taken in the middle of a line.
  `ASSERT_NEVER(a_no_mid_accept, clk_i, rst_ni, in_acc && (state_q == S_DATA || state_q == S_ID))
  // Data nibbles come in pairs: a line never closes on a high nibble.
  `ASSERT_PROP(a_data_pairs, clk_i, rst_ni, data_hi |=> (state_q == S_DATA || $past(!adv)))

endmodule
